/* src/mpmq_pkg.sv */
// ----------------------------------------------------------------------------
// mpmq_pkg
// Shared types, constants and helpers for the multi-pipe message queue.
// ----------------------------------------------------------------------------
package mpmq_pkg;

  localparam int PIPES     = 4;
  localparam int SLOTS     = 16;
  localparam int MSG_BYTES = 8;

  localparam int DATA_W   = 64;
  localparam int PIPE_W   = (PIPES > 1) ? $clog2(PIPES) : 1;
  localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CAP_W    = $clog2(SLOTS + 1);
  localparam int SIZE_W   = $clog2(MSG_BYTES + 1);
  localparam int ADDR_W   = (PIPES * SLOTS > 1) ? $clog2(PIPES * SLOTS) : 1;

  // configuration registers
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 32;
  localparam int CAP_REG_W   = 32;
  localparam int SIZE_REG_W  = 16;
  localparam int CAP_FIELDS  = CAP_REG_W / 8;
  localparam int SIZE_FIELDS = SIZE_REG_W / 4;
  localparam logic [CAP_REG_W-1:0]  CAP_RESET  = 32'h1010_1010;
  localparam logic [SIZE_REG_W-1:0] SIZE_RESET = 16'h8888;

  localparam logic [CFG_IDX_W-1:0] REG_CAPACITIES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MSG_SIZES  = 1'b1;

  // item queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_SEND    = 2'd0,
    OP_RECEIVE = 2'd1,
    OP_JAM     = 2'd2,
    OP_RESET   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BAD_PIPE = 3'd3,
    ST_BAD_SIZE = 3'd4
  } status_t;

  // classified item, as it leaves the front
  typedef struct packed {
    op_t                op;
    logic [PIPE_W-1:0]  pipe;
    logic               bad_pipe;
    logic               size_ok;
    logic [CAP_W-1:0]   cap;
    logic [SIZE_W-1:0]  size;
    logic [DATA_W-1:0]  data;
  } item_t;

  // one result, as registered by the back
  typedef struct packed {
    status_t            status;
    logic [SIZE_W-1:0]  len;
    logic [CAP_W-1:0]   held;
    logic [CAP_W-1:0]   free;
    logic [CAP_W-1:0]   cap;
    logic [SIZE_W-1:0]  size;
  } result_t;

  function automatic logic [DATA_W-1:0] byte_mask(input logic [SIZE_W-1:0] n);
    logic [DATA_W-1:0] m;
    m = '0;
    for (int i = 0; i < MSG_BYTES; i++) begin
      if (i < int'(n)) m[i*8 +: 8] = 8'hFF;
    end
    return m;
  endfunction

  function automatic logic [7:0] cap_field(input logic [CAP_REG_W-1:0] r,
                                           input logic [3:0] idx);
    logic [7:0] c;
    c = '0;
    for (int i = 0; i < CAP_FIELDS; i++) begin
      if (int'(idx) == i) c = r[i*8 +: 8];
    end
    return c;
  endfunction

  function automatic logic [3:0] size_field(input logic [SIZE_REG_W-1:0] r,
                                            input logic [3:0] idx);
    logic [3:0] s;
    s = '0;
    for (int i = 0; i < SIZE_FIELDS; i++) begin
      if (int'(idx) == i) s = r[i*4 +: 4];
    end
    return s;
  endfunction

endpackage

/* src/mpmq_front.sv */
// ----------------------------------------------------------------------------
// mpmq_front
// Holds the configuration registers and classifies each request: pipe check,
// capacity and size lookup with saturation, size check, data masking.
// ----------------------------------------------------------------------------
module mpmq_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  input  logic [mpmq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mpmq_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [1:0]                       operation,
  input  logic [3:0]                       pipe_index,
  input  logic [63:0]                      message_data,
  input  logic [3:0]                       length_given,
  output mpmq_pkg::item_t                  item
);

  logic [mpmq_pkg::CAP_REG_W-1:0]  capacities;
  logic [mpmq_pkg::SIZE_REG_W-1:0] msg_sizes;
  logic [7:0]                      cap_raw;
  logic [3:0]                      size_raw;
  logic [mpmq_pkg::CAP_W-1:0]      cap;
  logic [mpmq_pkg::SIZE_W-1:0]     size;
  logic                            bad_pipe;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacities <= mpmq_pkg::CAP_RESET;
      msg_sizes  <= mpmq_pkg::SIZE_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mpmq_pkg::REG_CAPACITIES: capacities <= cfg_data[mpmq_pkg::CAP_REG_W-1:0];
        mpmq_pkg::REG_MSG_SIZES:  msg_sizes  <= cfg_data[mpmq_pkg::SIZE_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    bad_pipe = ({1'b0, pipe_index} >= 5'(mpmq_pkg::PIPES));
    cap_raw  = mpmq_pkg::cap_field(capacities, pipe_index);
    size_raw = mpmq_pkg::size_field(msg_sizes, pipe_index);
    cap  = (int'(cap_raw) > mpmq_pkg::SLOTS) ? mpmq_pkg::CAP_W'(mpmq_pkg::SLOTS)
                                             : mpmq_pkg::CAP_W'(cap_raw);
    size = (int'(size_raw) > mpmq_pkg::MSG_BYTES) ? mpmq_pkg::SIZE_W'(mpmq_pkg::MSG_BYTES)
                                                  : mpmq_pkg::SIZE_W'(size_raw);
    // invalid pipe reports zero everywhere
    if (bad_pipe) begin
      cap  = '0;
      size = '0;
    end
    item.op       = mpmq_pkg::op_t'(operation);
    item.pipe     = pipe_index[mpmq_pkg::PIPE_W-1:0];
    item.bad_pipe = bad_pipe;
    item.size_ok  = ({1'b0, length_given} == 5'(size));
    item.cap      = cap;
    item.size     = size;
    item.data     = message_data & mpmq_pkg::byte_mask(size);
  end

endmodule

/* src/mpmq_queue.sv */
// ----------------------------------------------------------------------------
// mpmq_queue
// Short item queue between front and back.
// ----------------------------------------------------------------------------
module mpmq_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  mpmq_pkg::item_t push_item,
  output logic            full,
  output logic            not_empty,
  input  logic            pop,
  output mpmq_pkg::item_t pop_item
);

  mpmq_pkg::item_t                mem [mpmq_pkg::Q_DEPTH];
  logic [mpmq_pkg::Q_PTR_W-1:0]   wr_ptr;
  logic [mpmq_pkg::Q_PTR_W-1:0]   rd_ptr;
  logic [mpmq_pkg::Q_CNT_W-1:0]   count;
  logic                           do_push;
  logic                           do_pop;

  assign full      = (count == mpmq_pkg::Q_CNT_W'(mpmq_pkg::Q_DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == mpmq_pkg::Q_PTR_W'(mpmq_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == mpmq_pkg::Q_PTR_W'(mpmq_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

endmodule

/* src/mpmq_back.sv */
// ----------------------------------------------------------------------------
// mpmq_back
// Executes one classified item per cycle: per-pipe head, tail and count,
// the shared slot store, and the registered result.
// ----------------------------------------------------------------------------
module mpmq_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  input  mpmq_pkg::item_t                 item,
  output logic                            done,
  output mpmq_pkg::result_t               result,
  output logic [mpmq_pkg::DATA_W-1:0]     message
);

  logic [mpmq_pkg::SLOT_W-1:0] head_slot  [mpmq_pkg::PIPES];
  logic [mpmq_pkg::SLOT_W-1:0] tail_slot  [mpmq_pkg::PIPES];
  logic [mpmq_pkg::CAP_W-1:0]  held_count [mpmq_pkg::PIPES];
  logic [mpmq_pkg::DATA_W-1:0] slot_store [mpmq_pkg::PIPES * mpmq_pkg::SLOTS];
  logic [mpmq_pkg::DATA_W-1:0] rd_data;

  logic [mpmq_pkg::CAP_W-1:0]  held, held_next;
  logic [mpmq_pkg::SLOT_W-1:0] head, head_next, tail, tail_next, slot;
  logic [mpmq_pkg::CAP_W-1:0]  adv;
  logic [mpmq_pkg::ADDR_W-1:0] addr;
  logic                        wr_en, rd_en, upd;
  mpmq_pkg::status_t           status_next;
  logic [mpmq_pkg::SIZE_W-1:0] len_next;
  mpmq_pkg::result_t           result_next;

  always_comb begin
    held        = held_count[item.pipe];
    head        = head_slot[item.pipe];
    tail        = tail_slot[item.pipe];
    held_next   = held;
    head_next   = head;
    tail_next   = tail;
    slot        = head;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    len_next    = '0;
    status_next = mpmq_pkg::ST_OK;
    adv         = '0;
    priority if (item.bad_pipe) begin
      status_next = mpmq_pkg::ST_BAD_PIPE;
      held_next   = '0;
    end else if (item.op == mpmq_pkg::OP_RESET) begin
      held_next = '0;
      head_next = '0;
      tail_next = '0;
    end else if (!item.size_ok) begin
      status_next = mpmq_pkg::ST_BAD_SIZE;
    end else if (item.op == mpmq_pkg::OP_RECEIVE) begin
      if (held == '0) begin
        status_next = mpmq_pkg::ST_EMPTY;
      end else begin
        slot      = tail;
        rd_en     = 1'b1;
        len_next  = item.size;
        adv       = mpmq_pkg::CAP_W'(tail) + 1'b1;
        tail_next = (adv >= item.cap) ? '0 : mpmq_pkg::SLOT_W'(adv);
        held_next = held - 1'b1;
      end
    end else if (held >= item.cap) begin
      status_next = mpmq_pkg::ST_FULL;
    end else if (item.op == mpmq_pkg::OP_SEND) begin
      slot      = head;
      wr_en     = 1'b1;
      adv       = mpmq_pkg::CAP_W'(head) + 1'b1;
      head_next = (adv >= item.cap) ? '0 : mpmq_pkg::SLOT_W'(adv);
      held_next = held + 1'b1;
    end else begin
      // jam: step the tail back, wrapping to the top of the capacity
      if (tail == '0 || mpmq_pkg::CAP_W'(tail) > item.cap) begin
        tail_next = mpmq_pkg::SLOT_W'(item.cap - 1'b1);
      end else begin
        tail_next = tail - 1'b1;
      end
      slot      = tail_next;
      wr_en     = 1'b1;
      held_next = held + 1'b1;
    end

    addr = mpmq_pkg::ADDR_W'(item.pipe) * mpmq_pkg::ADDR_W'(mpmq_pkg::SLOTS)
         + mpmq_pkg::ADDR_W'(slot);
    upd  = item_valid && !item.bad_pipe;

    result_next.status = status_next;
    result_next.len    = len_next;
    result_next.held   = held_next;
    result_next.free   = (held_next >= item.cap) ? '0 : item.cap - held_next;
    result_next.cap    = item.cap;
    result_next.size   = item.size;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < mpmq_pkg::PIPES; i++) begin
        head_slot[i]  <= '0;
        tail_slot[i]  <= '0;
        held_count[i] <= '0;
      end
    end else if (upd) begin
      head_slot[item.pipe]  <= head_next;
      tail_slot[item.pipe]  <= tail_next;
      held_count[item.pipe] <= held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && wr_en) slot_store[addr] <= item.data;
    if (item_valid && rd_en) rd_data <= slot_store[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid) result <= result_next;
  end

  // len is zero unless the receive succeeded, which clears the whole word
  assign message = rd_data & mpmq_pkg::byte_mask(result.len);

endmodule

/* src/multi_pipe_message_queue_top.sv */
// ----------------------------------------------------------------------------
// multi_pipe_message_queue_top
// Several ring-buffer message pipes sharing one slot store.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive operation, pipe_index, message_data and
//   length_given with start high; the item is taken on a clock edge where
//   busy is low. One item can be taken every cycle.
//   Result channel: done pulses for one cycle with status, message_out,
//   length_returned, messages_held, slots_free, capacity_of_pipe and
//   size_of_message. The receiver has no backpressure and must take it.
//   The accepted item sits in the item queue while the execute stage works
//   on it, then the registered result and slot store read show with done.
//   Throughput is one item per cycle, set by the execute stage, which
//   updates one pipe per cycle.
//   Configuration: cfg_valid/cfg_ready with cfg_index (0 capacities, 1
//   message sizes) and cfg_data; cfg_ready is always high. Write only while
//   no item is in flight.
//   Reset (rst, synchronous) empties every pipe and restores the default
//   configuration; slot contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module multi_pipe_message_queue_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      operation,
  input  logic [3:0]                      pipe_index,
  input  logic [63:0]                     message_data,
  input  logic [3:0]                      length_given,
  output logic                            done,
  output logic [2:0]                      status,
  output logic [63:0]                     message_out,
  output logic [3:0]                      length_returned,
  output logic [4:0]                      messages_held,
  output logic [4:0]                      slots_free,
  output logic [4:0]                      capacity_of_pipe,
  output logic [3:0]                      size_of_message,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mpmq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mpmq_pkg::CFG_DATA_W-1:0] cfg_data
);

  mpmq_pkg::item_t             front_item;
  mpmq_pkg::item_t             back_item;
  mpmq_pkg::result_t           result;
  logic                        q_full;
  logic                        q_not_empty;
  logic [mpmq_pkg::DATA_W-1:0] message;

  assign cfg_ready = 1'b1;
  assign busy      = q_full;

  mpmq_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .operation    (operation),
    .pipe_index   (pipe_index),
    .message_data (message_data),
    .length_given (length_given),
    .item         (front_item)
  );

  mpmq_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (start),
    .push_item (front_item),
    .full      (q_full),
    .not_empty (q_not_empty),
    .pop       (q_not_empty),
    .pop_item  (back_item)
  );

  mpmq_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (q_not_empty),
    .item       (back_item),
    .done       (done),
    .result     (result),
    .message    (message)
  );

  assign status           = result.status;
  assign message_out      = message;
  assign length_returned  = 4'(result.len);
  assign messages_held    = 5'(result.held);
  assign slots_free       = 5'(result.free);
  assign capacity_of_pipe = 5'(result.cap);
  assign size_of_message  = 4'(result.size);

endmodule

/* src/mpmq_checker.sv */
// ----------------------------------------------------------------------------
// mpmq_checker
// Port-level checks for the message queue top level.
// ----------------------------------------------------------------------------
module mpmq_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            start,
  input logic                            busy,
  input logic                            done,
  input logic [2:0]                      status,
  input logic [63:0]                     message_out,
  input logic [3:0]                      length_returned,
  input logic [4:0]                      messages_held,
  input logic [4:0]                      slots_free,
  input logic [4:0]                      capacity_of_pipe,
  input logic [3:0]                      size_of_message
);

  // every accepted item yields exactly one result
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("accepted item produced no result");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("result without an accepted item");

  a_fail_no_data: assert property (@(posedge clk) disable iff (rst)
    (done && status != mpmq_pkg::ST_OK) |-> (length_returned == '0 && message_out == '0))
    else $error("failed request returned message data");

  a_bad_pipe_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status == mpmq_pkg::ST_BAD_PIPE) |->
      (messages_held == '0 && slots_free == '0 && capacity_of_pipe == '0 &&
       size_of_message == '0))
    else $error("invalid pipe reported pipe state");

  a_free_count: assert property (@(posedge clk) disable iff (rst)
    done |-> (slots_free == '0 ||
              ({1'b0, slots_free} + {1'b0, messages_held}) == {1'b0, capacity_of_pipe}))
    else $error("free slots inconsistent with count and capacity");

endmodule

bind multi_pipe_message_queue_top mpmq_checker u_mpmq_checker (.*);

/* sim/multi_pipe_message_queue_top_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multi_pipe_message_queue_top_tb
// Self-checking bench for the multi-pipe message queue. A scoreboard tracks
// every pipe's ring pointers, counts and slot contents, predicts the result
// of each accepted request and compares it with what the block returns.
// Traffic runs through several capacity and message-size settings, with
// random idle gaps on the request side.
// ----------------------------------------------------------------------------
module multi_pipe_message_queue_top_tb;
  import mpmq_pkg::*;

  localparam int CYCLE_LIMIT = 300000;

  typedef struct {
    status_t     stat;
    logic [63:0] msg;
    logic [3:0]  len;
    logic [4:0]  held_n;
    logic [4:0]  free_n;
    logic [4:0]  cap_n;
    logic [3:0]  size_n;
  } reply_t;

  class pipe_scoreboard;
    logic [31:0] caps_reg;
    logic [15:0] sizes_reg;
    logic [63:0] slot_data [PIPES*SLOTS];
    bit          slot_written [PIPES*SLOTS];
    int unsigned head [PIPES];
    int unsigned tail [PIPES];
    int unsigned held [PIPES];
    reply_t      replies [$];
    int unsigned status_hits [5];
    int unsigned accepted;
    int unsigned checked;
    int unsigned errors;

    function new();
      caps_reg  = CAP_RESET;
      sizes_reg = SIZE_RESET;
    endfunction

    function int unsigned capacity(int unsigned p);
      int unsigned c;
      if (p >= PIPES) return 0;
      c = caps_reg[p*8 +: 8];
      return (c > SLOTS) ? SLOTS : c;
    endfunction

    function int unsigned msg_size(int unsigned p);
      int unsigned s;
      if (p >= PIPES) return 0;
      s = sizes_reg[p*4 +: 4];
      return (s > MSG_BYTES) ? MSG_BYTES : s;
    endfunction

    function logic [63:0] keep_bytes(int unsigned n);
      if (n >= 8) return '1;
      return (64'd1 << (n * 8)) - 64'd1;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
      if (idx == REG_CAPACITIES) caps_reg = value;
      else sizes_reg = value[15:0];
    endfunction

    function int unsigned pending();
      return replies.size();
    endfunction

    // true when this request would pop a slot the block has never written
    function bit would_read_blank(op_t op, int unsigned p, int unsigned len);
      if (op != OP_RECEIVE || p >= PIPES) return 0;
      if (len != msg_size(p) || held[p] == 0) return 0;
      return !slot_written[p*SLOTS + tail[p] % SLOTS];
    endfunction

    function void note_item(op_t op, int unsigned p, logic [63:0] data, int unsigned len);
      reply_t r;
      int unsigned cap, sz, cnt, ptr, base;
      r.stat   = ST_OK;
      r.msg    = '0;
      r.len    = '0;
      r.held_n = '0;
      r.free_n = '0;
      r.cap_n  = '0;
      r.size_n = '0;
      accepted++;
      if (p >= PIPES) begin
        r.stat = ST_BAD_PIPE;
      end else begin
        cap  = capacity(p);
        sz   = msg_size(p);
        cnt  = held[p];
        base = p * SLOTS;
        if (op == OP_RESET) begin
          head[p] = 0;
          tail[p] = 0;
          held[p] = 0;
        end else if (len != sz) begin
          r.stat = ST_BAD_SIZE;
        end else if (op == OP_RECEIVE) begin
          if (cnt == 0) begin
            r.stat = ST_EMPTY;
          end else begin
            ptr = tail[p] % SLOTS;
            r.msg = slot_data[base + ptr] & keep_bytes(sz);
            r.len = 4'(sz);
            ptr++;
            tail[p] = (ptr >= cap) ? 0 : ptr;
            held[p] = cnt - 1;
          end
        end else if (cnt >= cap) begin
          // also covers a pipe left holding more than a shrunken capacity
          r.stat = ST_FULL;
        end else if (op == OP_SEND) begin
          ptr = head[p] % SLOTS;
          slot_data[base + ptr]    = data & keep_bytes(sz);
          slot_written[base + ptr] = 1'b1;
          ptr++;
          head[p] = (ptr >= cap) ? 0 : ptr;
          held[p] = cnt + 1;
        end else begin
          ptr = tail[p];
          ptr = (ptr == 0 || ptr > cap) ? cap - 1 : ptr - 1;
          tail[p] = ptr;
          slot_data[base + ptr % SLOTS]    = data & keep_bytes(sz);
          slot_written[base + ptr % SLOTS] = 1'b1;
          held[p] = cnt + 1;
        end
        cnt = held[p];
        r.held_n = 5'(cnt);
        r.free_n = (cnt >= cap) ? 5'd0 : 5'(cap - cnt);
        r.cap_n  = 5'(cap);
        r.size_n = 4'(sz);
      end
      status_hits[r.stat]++;
      replies.push_back(r);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_reply(logic [2:0] st, logic [63:0] msg, logic [3:0] len,
                              logic [4:0] held_n, logic [4:0] free_n,
                              logic [4:0] cap_n, logic [3:0] size_n);
      reply_t e;
      if (replies.size() == 0) begin
        $error("result with no request outstanding (status %0d)", st);
        errors++;
        return;
      end
      e = replies.pop_front();
      checked++;
      compare_field("status", e.stat, st);
      compare_field("message_out", e.msg, msg);
      compare_field("length_returned", e.len, len);
      compare_field("messages_held", e.held_n, held_n);
      compare_field("slots_free", e.free_n, free_n);
      compare_field("capacity_of_pipe", e.cap_n, cap_n);
      compare_field("size_of_message", e.size_n, size_n);
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic [1:0]            operation;
  logic [3:0]            pipe_index;
  logic [63:0]           message_data;
  logic [3:0]            length_given;
  logic                  done;
  logic [2:0]            status;
  logic [63:0]           message_out;
  logic [3:0]            length_returned;
  logic [4:0]            messages_held;
  logic [4:0]            slots_free;
  logic [4:0]            capacity_of_pipe;
  logic [3:0]            size_of_message;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pipe_scoreboard sb;
  int unsigned    cycles;
  int unsigned    cfg_writes;
  bit             steady;

  multi_pipe_message_queue_top dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .operation        (operation),
    .pipe_index       (pipe_index),
    .message_data     (message_data),
    .length_given     (length_given),
    .done             (done),
    .status           (status),
    .message_out      (message_out),
    .length_returned  (length_returned),
    .messages_held    (messages_held),
    .slots_free       (slots_free),
    .capacity_of_pipe (capacity_of_pipe),
    .size_of_message  (size_of_message),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (!rst && done !== 1'b0)
      sb.check_reply(status, message_out, length_returned, messages_held,
                     slots_free, capacity_of_pipe, size_of_message);
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  function automatic logic [63:0] pick_data();
    case ($urandom_range(0, 9))
      0: return '1;
      1: return '0;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  task automatic push_item(op_t op, logic [3:0] p, logic [63:0] data, logic [3:0] len);
    int unsigned gap;
    start        <= 1'b1;
    operation    <= op;
    pipe_index   <= p;
    message_data <= data;
    length_given <= len;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    sb.note_item(op, p, data, len);
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      // junk on the request fields while start is low
      start        <= 1'b0;
      operation    <= 2'($urandom());
      pipe_index   <= 4'($urandom());
      message_data <= {$urandom(), $urandom()};
      length_given <= 4'($urandom());
      repeat (gap) @(posedge clk);
    end
  endtask

  // wait for every outstanding result, then idle for pipeline slack
  task automatic settle();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_handshake();
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    sb.set_reg(cfg_index, cfg_data);
    cfg_writes++;
  endtask

  task automatic apply_config(logic [31:0] caps, logic [31:0] sizes_word);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= REG_CAPACITIES;
    cfg_data  <= caps;
    cfg_handshake();
    cfg_index <= REG_MSG_SIZES;
    cfg_data  <= sizes_word;
    cfg_handshake();
    cfg_valid <= 1'b0;
  endtask

  task automatic random_items(int unsigned count);
    int unsigned fill_bias;
    int unsigned p;
    int unsigned len;
    op_t         op;
    fill_bias = 50;
    for (int unsigned i = 0; i < count; i++) begin
      // bursts that lean toward filling or draining, some with no gaps
      if (i % 40 == 0) begin
        fill_bias = $urandom_range(20, 80);
        steady    = ($urandom_range(0, 3) == 0);
      end
      p = ($urandom_range(0, 99) < 92) ? $urandom_range(0, PIPES - 1)
                                       : $urandom_range(PIPES, 15);
      len = ($urandom_range(0, 99) < 90 && p < PIPES) ? sb.msg_size(p)
                                                       : $urandom_range(0, 15);
      if ($urandom_range(0, 99) < 4)
        op = OP_RESET;
      else if ($urandom_range(0, 99) < fill_bias)
        op = ($urandom_range(0, 3) != 0) ? OP_SEND : OP_JAM;
      else
        op = OP_RECEIVE;
      if (sb.would_read_blank(op, p, len)) op = OP_SEND;
      push_item(op, 4'(p), pick_data(), 4'(len));
    end
    steady = 1'b0;
  endtask

  initial begin
    sb = new();
    rst          <= 1'b1;
    start        <= 1'b0;
    operation    <= OP_SEND;
    pipe_index   <= '0;
    message_data <= '0;
    length_given <= '0;
    cfg_valid    <= 1'b0;
    cfg_index    <= REG_CAPACITIES;
    cfg_data     <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // default settings: every pipe holds 16 messages of 8 bytes
    push_item(OP_SEND, 4'd4, '1, 4'd8);
    push_item(OP_RECEIVE, 4'd15, '0, 4'd15);
    push_item(OP_RESET, 4'd9, '1, 4'd0);
    push_item(OP_SEND, 4'd0, '1, 4'd8);
    push_item(OP_SEND, 4'd0, '0, 4'd8);
    push_item(OP_JAM, 4'd0, 64'hA5A5_5A5A_0F0F_F0F0, 4'd8);   // tail wraps to the top
    push_item(OP_SEND, 4'd0, '1, 4'd7);
    push_item(OP_RECEIVE, 4'd0, '0, 4'd0);
    push_item(OP_JAM, 4'd0, '1, 4'd15);
    push_item(OP_RECEIVE, 4'd0, '0, 4'd8);
    push_item(OP_RECEIVE, 4'd0, '0, 4'd8);
    push_item(OP_RECEIVE, 4'd0, '0, 4'd8);
    push_item(OP_RECEIVE, 4'd0, '0, 4'd8);
    push_item(OP_SEND, 4'd3, 64'h0123_4567_89AB_CDEF, 4'd8);
    push_item(OP_RESET, 4'd3, '0, 4'd5);                      // size is ignored
    push_item(OP_RECEIVE, 4'd3, '0, 4'd8);

    // caps 0, 1, 3 and a saturating 20; sizes 3, 0, 1 and a saturating 15
    apply_config(32'h1403_0100, 32'h0000_F103);
    push_item(OP_SEND, 4'd0, '1, 4'd3);
    push_item(OP_RECEIVE, 4'd0, '0, 4'd3);
    push_item(OP_JAM, 4'd0, '1, 4'd3);
    push_item(OP_SEND, 4'd1, '1, 4'd0);
    push_item(OP_SEND, 4'd1, '1, 4'd0);
    push_item(OP_JAM, 4'd1, '1, 4'd0);
    push_item(OP_RECEIVE, 4'd1, '0, 4'd0);
    push_item(OP_SEND, 4'd2, '1, 4'd1);
    push_item(OP_RECEIVE, 4'd2, '0, 4'd1);

    apply_config(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    random_items(150);
    apply_config(32'h0000_0000, 32'h0000_0000);
    random_items(50);
    apply_config(32'h1010_1010, 32'h0000_8888);
    random_items(130);
    apply_config(32'h0201_0403, 32'hABCD_1234);
    random_items(130);
    apply_config(32'h0510_0208, 32'h0000_07F5);
    random_items(130);
    for (int ph = 0; ph < 4; ph++) begin
      apply_config({8'($urandom_range(0, 20)), 8'($urandom_range(0, 20)),
                    8'($urandom_range(0, 20)), 8'($urandom_range(0, 255))},
                   $urandom());
      random_items(140);
    end

    settle();
    repeat (8) @(posedge clk);
    if (sb.pending() != 0) begin
      $error("%0d expected results never arrived", sb.pending());
      sb.errors++;
    end
    $display("%0d requests accepted, %0d results checked, %0d register writes",
             sb.accepted, sb.checked, cfg_writes);
    $display("outcomes: ok %0d, full %0d, empty %0d, bad pipe %0d, bad size %0d",
             sb.status_hits[ST_OK], sb.status_hits[ST_FULL], sb.status_hits[ST_EMPTY],
             sb.status_hits[ST_BAD_PIPE], sb.status_hits[ST_BAD_SIZE]);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
